### rtl/core/sppt_pkg.sv
// types, codes and constants shared by the shaped pulse power table
// no dependencies
package sppt_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_PULSE,
		ST_BAD_COUNT,
		ST_BEYOND
	} status_t;

	// shape modes
	localparam logic [1:0] MODE_RISE  = 2'd0;
	localparam logic [1:0] MODE_FALL  = 2'd1;
	localparam logic [1:0] MODE_GAUSS = 2'd2;
	localparam logic [1:0] MODE_HERM  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
	localparam logic [2:0] REG_REQ_INTV   = 3'd1;
	localparam logic [2:0] REG_PULSE_W    = 3'd2;
	localparam logic [2:0] REG_PEAK_PWR   = 3'd3;
	localparam logic [2:0] REG_HERM_A     = 3'd4;
	localparam logic [2:0] REG_HERM_B     = 3'd5;

	// arithmetic constants
	localparam int          DIV_BITS     = 44;
	localparam int          SQR_STEPS    = 16;
	localparam logic [5:0]  SPAN_MAX     = 6'd40;
	localparam logic [9:0]  POWER_MAX    = 10'd63;
	localparam logic [9:0]  HALF_EDGE_DB = 10'd6;
	localparam logic [23:0] ONE_Q16      = 24'd65536;
	localparam logic signed [37:0] LOG10_2_Q16 = 38'sd19728;
	localparam logic signed [41:0] LOG10_E_Q16 = 42'sd28462;
	localparam logic signed [41:0] ONE_Q32     = 42'sd4294967296;

	typedef struct packed {
		logic [1:0]  shape_mode;
		logic [9:0]  requested_intervals;
		logic [19:0] pulse_width;
		logic [5:0]  peak_power;
		logic [23:0] herm_a;
		logic [23:0] herm_b;
	} cfg_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_FAIL,
		OP_REDUCE,
		OP_SETUP,
		OP_MUL1,
		OP_MUL2,
		OP_DIV,
		OP_STORE,
		OP_MPREP,
		OP_NORM,
		OP_SQRINIT,
		OP_SQR,
		OP_LOG1,
		OP_LOG2,
		OP_SCALE,
		OP_FINAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    sel_b;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		logic no_pulse;
		logic bad_count;
		logic reduce_more;
		logic reduce_fail;
		logic beyond;
		logic hermite;
		logic m_zero;
		logic norm_done;
	} dp_stat_t;

endpackage

### rtl/core/sppt_datapath.sv
// datapath of the shaped pulse power table: count reduction, shape ratio,
// shared restoring divider, log2 by squaring and final power; uses sppt_pkg
module sppt_datapath #(
	parameter int MIN_INTERVAL_TICKS = 100,
	parameter int MAX_INTERVALS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sppt_pkg::cfg_t    cfg,
	input  logic [9:0]        interval_index,
	input  sppt_pkg::dp_cmd_t cmd,
	output sppt_pkg::dp_stat_t stat,
	output logic [6:0]        power_db,
	output logic              phase_inverted,
	output logic [9:0]        intervals_used,
	output logic              last_interval,
	output logic [1:0]        status
);
	import sppt_pkg::*;

	localparam int PROD_W = $clog2(MIN_INTERVAL_TICKS + 1) + 10;
	localparam int CMP_W = (PROD_W > 20) ? PROD_W : 20;
	localparam logic [PROD_W-1:0] MIN_T = PROD_W'(MIN_INTERVAL_TICKS);
	localparam logic [PROD_W-1:0] STEP2 = PROD_W'(2 * MIN_INTERVAL_TICKS);

	logic [9:0]        idx_q, n_q;
	logic [PROD_W-1:0] prod_q;
	logic [5:0]        span_q;
	logic [4:0]        base_q;
	logic [11:0]       fa_q, fb_q;
	logic [9:0]        d_q;
	logic [21:0]       den_q;
	logic              edge_q, last_q, inv_q;
	logic [33:0]       mul_q;
	logic [43:0]       dq_q;
	logic [22:0]       div_q, rem_q;
	logic [23:0]       au2_q, bu2_q, norm_q;
	logic [4:0]        e_q;
	logic [30:0]       x_q;
	logic [15:0]       frac_q;
	logic signed [37:0] t1_q;
	logic signed [41:0] lq_q;
	logic signed [9:0]  pwr_q;
	logic              herm;

	assign herm = (cfg.shape_mode == MODE_HERM);

	// status toward the controller
	always_comb begin
		stat.no_pulse    = (cfg.pulse_width == 20'd0);
		stat.bad_count   = (n_q == 10'd0) || (32'(n_q) > 32'(MAX_INTERVALS));
		stat.reduce_more = (CMP_W'(cfg.pulse_width) < CMP_W'(prod_q));
		stat.reduce_fail = (n_q <= 10'd2);
		stat.beyond      = (idx_q >= n_q);
		stat.hermite     = herm;
		stat.m_zero      = (au2_q == ONE_Q16);
		stat.norm_done   = norm_q[23];
	end

	// setup terms
	logic [10:0] p_w, q_w, n_w, pp_w, d_w, side_w;
	logic [11:0] fa_w, fb_w;
	always_comb begin
		p_w  = {idx_q, 1'b1};
		q_w  = {n_q, 1'b0};
		n_w  = {1'b0, n_q};
		pp_w = (cfg.shape_mode == MODE_FALL) ? (q_w - p_w) : p_w;
		d_w  = (p_w >= n_w) ? (p_w - n_w) : (n_w - p_w);
		if (cfg.shape_mode == MODE_RISE || cfg.shape_mode == MODE_FALL) begin
			fa_w   = {1'b0, pp_w};
			fb_w   = {q_w, 1'b0} - fa_w;
			side_w = q_w;
		end else begin
			fa_w   = {1'b0, p_w};
			fb_w   = {1'b0, q_w - p_w};
			side_w = n_w;
		end
	end

	// divider step
	logic [23:0] tmp_w;
	logic        ge_w;
	assign tmp_w = {rem_q, dq_q[43]};
	assign ge_w  = (tmp_w >= {1'b0, div_q});

	// squaring step
	logic [61:0] sq_w;
	logic [31:0] y_w;
	assign sq_w = 62'(x_q) * 62'(x_q);
	assign y_w  = sq_w[61:30];

	// log terms
	logic signed [21:0] lg_w;
	logic signed [41:0] bterm_w;
	logic [46:0]        scl_w;
	logic signed [9:0]  sat_w;
	assign lg_w    = {6'({1'b0, e_q}) - 6'd16, frac_q};
	assign bterm_w = $signed({18'b0, bu2_q}) * LOG10_E_Q16;
	assign scl_w   = 47'(lq_q[40:0]) * 47'(span_q) + 47'(32'h8000_0000);
	assign sat_w   = (pwr_q > $signed(POWER_MAX)) ? $signed(POWER_MAX) : pwr_q;

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				idx_q  <= interval_index;
				n_q    <= cfg.requested_intervals;
				prod_q <= MIN_T * PROD_W'(cfg.requested_intervals);
			end
			OP_REDUCE: begin
				n_q    <= n_q - 10'd2;
				prod_q <= prod_q - STEP2;
			end
			OP_SETUP: begin
				if (cfg.peak_power > SPAN_MAX) begin
					span_q <= SPAN_MAX;
					base_q <= 5'(cfg.peak_power - SPAN_MAX);
				end else begin
					span_q <= cfg.peak_power;
					base_q <= 5'd0;
				end
				fa_q   <= fa_w;
				fb_q   <= fb_w;
				d_q    <= d_w[9:0];
				den_q  <= 22'(side_w) * 22'(side_w);
				edge_q <= (cfg.shape_mode == MODE_RISE && idx_q == n_q - 10'd1) ||
					(cfg.shape_mode == MODE_FALL && idx_q == 10'd0);
				last_q <= (idx_q == n_q - 10'd1);
				inv_q  <= 1'b0;
			end
			OP_MUL1: begin
				if (herm)
					mul_q <= 34'(cmd.sel_b ? cfg.herm_b : cfg.herm_a) * 34'(d_q);
				else
					mul_q <= 34'(fa_q) * 34'(fb_q);
			end
			OP_MUL2: begin
				rem_q <= 23'd0;
				if (herm) begin
					dq_q  <= 44'(mul_q) * 44'(d_q);
					div_q <= {1'b0, den_q};
				end else begin
					dq_q  <= ((44'(mul_q) * 44'(span_q)) << 1) + 44'(den_q);
					div_q <= {den_q, 1'b0};
				end
			end
			OP_DIV: begin
				rem_q <= ge_w ? 23'(tmp_w - {1'b0, div_q}) : tmp_w[22:0];
				dq_q  <= {dq_q[42:0], ge_w};
			end
			OP_STORE: begin
				if (!herm)
					pwr_q <= $signed(10'(base_q)) + $signed(10'(dq_q[6:0])) -
						(edge_q ? $signed(HALF_EDGE_DB) : 10'sd0);
				else if (cmd.sel_b)
					bu2_q <= dq_q[23:0];
				else
					au2_q <= dq_q[23:0];
			end
			OP_MPREP: begin
				norm_q <= (au2_q >= ONE_Q16) ? (au2_q - ONE_Q16) : (ONE_Q16 - au2_q);
				e_q    <= 5'd23;
				lq_q   <= 42'sd0;
			end
			OP_NORM: begin
				norm_q <= {norm_q[22:0], 1'b0};
				e_q    <= e_q - 5'd1;
			end
			OP_SQRINIT: begin
				x_q    <= {norm_q, 7'b0};
				frac_q <= 16'd0;
			end
			OP_SQR: begin
				x_q    <= y_w[31] ? y_w[31:1] : y_w[30:0];
				frac_q <= {frac_q[14:0], y_w[31]};
			end
			OP_LOG1: begin
				t1_q <= 38'(lg_w) * LOG10_2_Q16;
			end
			OP_LOG2: begin
				lq_q <= ONE_Q32 + 42'(t1_q) - bterm_w;
			end
			OP_SCALE: begin
				if (lq_q > 42'sd0) begin
					inv_q <= (au2_q > ONE_Q16);
					pwr_q <= $signed(10'(base_q)) + $signed({1'b0, scl_w[40:32]});
				end else begin
					inv_q <= 1'b0;
					pwr_q <= $signed(10'(base_q));
				end
			end
			default: begin
			end
		endcase
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_db       <= 7'd0;
			phase_inverted <= 1'b0;
			intervals_used <= 10'd0;
			last_interval  <= 1'b0;
			status         <= ST_OK;
		end else if (cmd.op == OP_FINAL) begin
			power_db       <= sat_w[6:0];
			phase_inverted <= inv_q;
			intervals_used <= n_q;
			last_interval  <= last_q;
			status         <= ST_OK;
		end else if (cmd.op == OP_FAIL) begin
			power_db       <= 7'd0;
			phase_inverted <= 1'b0;
			intervals_used <= (cmd.st == ST_BEYOND) ? n_q : 10'd0;
			last_interval  <= 1'b0;
			status         <= cmd.st;
		end
	end

endmodule

### rtl/core/sppt_ctrl.sv
// controller state machine of the shaped pulse power table
// sequences the datapath operations; uses sppt_pkg
module sppt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sppt_pkg::dp_stat_t stat,
	output sppt_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import sppt_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CHECK   = 5'd1;
	localparam logic [4:0] S_REDUCE  = 5'd2;
	localparam logic [4:0] S_SETUP   = 5'd3;
	localparam logic [4:0] S_MUL1    = 5'd4;
	localparam logic [4:0] S_MUL2    = 5'd5;
	localparam logic [4:0] S_DIV     = 5'd6;
	localparam logic [4:0] S_STORE   = 5'd7;
	localparam logic [4:0] S_MPREP   = 5'd8;
	localparam logic [4:0] S_NORM    = 5'd9;
	localparam logic [4:0] S_SQRINIT = 5'd10;
	localparam logic [4:0] S_SQR     = 5'd11;
	localparam logic [4:0] S_LOG1    = 5'd12;
	localparam logic [4:0] S_LOG2    = 5'd13;
	localparam logic [4:0] S_SCALE   = 5'd14;
	localparam logic [4:0] S_FINAL   = 5'd15;
	localparam logic [4:0] S_OUT     = 5'd16;

	localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);
	localparam logic [5:0] SQR_LAST = 6'(SQR_STEPS - 1);

	logic [4:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       pass_b_q, pass_b_d;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

	// next state and command
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pass_b_d  = pass_b_q;
		cmd.op    = OP_NONE;
		cmd.sel_b = pass_b_q;
		cmd.st    = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.no_pulse) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_NO_PULSE;
					state_d = S_OUT;
				end else if (stat.bad_count) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_BAD_COUNT;
					state_d = S_OUT;
				end else begin
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				priority if (stat.reduce_more && stat.reduce_fail) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_BAD_COUNT;
					state_d = S_OUT;
				end else if (stat.reduce_more) begin
					cmd.op = OP_REDUCE;
				end else if (stat.beyond) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_BEYOND;
					state_d = S_OUT;
				end else begin
					pass_b_d = 1'b0;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.op  = OP_SETUP;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				cnt_d   = 6'd0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == DIV_LAST)
					state_d = S_STORE;
			end
			S_STORE: begin
				cmd.op = OP_STORE;
				priority if (!stat.hermite) begin
					state_d = S_FINAL;
				end else if (!pass_b_q) begin
					pass_b_d = 1'b1;
					state_d  = S_MUL1;
				end else begin
					state_d = S_MPREP;
				end
			end
			S_MPREP: begin
				cmd.op  = OP_MPREP;
				state_d = stat.m_zero ? S_SCALE : S_NORM;
			end
			S_NORM: begin
				if (stat.norm_done)
					state_d = S_SQRINIT;
				else
					cmd.op = OP_NORM;
			end
			S_SQRINIT: begin
				cmd.op  = OP_SQRINIT;
				cnt_d   = 6'd0;
				state_d = S_SQR;
			end
			S_SQR: begin
				cmd.op = OP_SQR;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == SQR_LAST)
					state_d = S_LOG1;
			end
			S_LOG1: begin
				cmd.op  = OP_LOG1;
				state_d = S_LOG2;
			end
			S_LOG2: begin
				cmd.op  = OP_LOG2;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.op  = OP_FINAL;
				state_d = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= 6'd0;
			pass_b_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			pass_b_q <= pass_b_d;
		end
	end

endmodule

### rtl/core/shaped_pulse_power_table.sv
// shaped pulse power table, top level: configuration registers, controller
// and datapath; uses sppt_pkg, sppt_ctrl, sppt_datapath
//
// Usage: configure shape_mode, requested_intervals, pulse_width, peak_power,
// herm_a and herm_b through the cfg_valid/cfg_ready write channel (cfg_ready
// is always high) while the block is idle. A query transfer happens at a
// clock edge with start high and busy low; interval_index is sampled there.
// busy stays high until the result has been shown. The result (power_db,
// phase_inverted, intervals_used, last_interval, status) appears for
// exactly one cycle with done high; the receiver cannot stall it.
// A query first checks for no pulse or a bad requested count, then lowers
// the count in up to 511 reduction steps of 2 intervals; a count that fails
// there or an index beyond the count ends it. The rise, fall and gauss shapes
// then take one pass through the 44-step restoring divider; the hermite shape
// takes two divider passes, and unless |1 - Au2| is zero a normalize shift
// and 16 log2 squaring steps follow.
// One query is in flight at a time; the next can be taken in the cycle after
// the result cycle. Reset returns the configuration and result registers to
// their defaults and the controller to idle.
module shaped_pulse_power_table #(
	parameter int MIN_INTERVAL_TICKS = 100,
	parameter int MAX_INTERVALS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  interval_index,
	output logic        done,
	output logic [6:0]  power_db,
	output logic        phase_inverted,
	output logic [9:0]  intervals_used,
	output logic        last_interval,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import sppt_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_mode          <= MODE_GAUSS;
			cfg_q.requested_intervals <= 10'd79;
			cfg_q.pulse_width         <= 20'd0;
			cfg_q.peak_power          <= 6'd0;
			cfg_q.herm_a              <= 24'd0;
			cfg_q.herm_b              <= 24'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHAPE_MODE: cfg_q.shape_mode          <= cfg_data[1:0];
				REG_REQ_INTV:   cfg_q.requested_intervals <= cfg_data[9:0];
				REG_PULSE_W:    cfg_q.pulse_width         <= cfg_data[19:0];
				REG_PEAK_PWR:   cfg_q.peak_power          <= cfg_data[5:0];
				REG_HERM_A:     cfg_q.herm_a              <= cfg_data;
				REG_HERM_B:     cfg_q.herm_b              <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sppt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sppt_datapath #(
		.MIN_INTERVAL_TICKS (MIN_INTERVAL_TICKS),
		.MAX_INTERVALS      (MAX_INTERVALS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.interval_index (interval_index),
		.cmd            (cmd),
		.stat           (stat),
		.power_db       (power_db),
		.phase_inverted (phase_inverted),
		.intervals_used (intervals_used),
		.last_interval  (last_interval),
		.status         (status)
	);

	// checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("query not taken");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (power_db == 7'd0 && !phase_inverted &&
		!last_interval)) else $error("failed query carries a power value");

endmodule

### dv/sppt_checker.sv
`timescale 1ns / 1ps
// result checker for the shaped pulse power table: tracks register writes,
// predicts each query result and compares it; uses sppt_pkg
module sppt_checker #(
	parameter int MIN_INTERVAL_TICKS = 100,
	parameter int MAX_INTERVALS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [9:0]  interval_index,
	input  logic        done,
	input  logic [6:0]  power_db,
	input  logic        phase_inverted,
	input  logic [9:0]  intervals_used,
	input  logic        last_interval,
	input  logic [1:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);
	import sppt_pkg::*;

	typedef struct packed {
		logic [6:0]  power_db;
		logic        phase_inverted;
		logic [9:0]  intervals_used;
		logic        last_interval;
		status_t     status;
	} interval_result_t;

	cfg_t             regs;
	interval_result_t expected_results[$];

	assign pending = expected_results.size();

	// power and phase of one interval under the current registers
	function automatic interval_result_t interval_power(logic [9:0] idx);
		longint n, pwr, lq, l2;
		longint unsigned span, base, un, p, q, d, nn, au2, bu2, m, x, frac;
		int e;
		bit inv;
		interval_result_t r;
		r = '0;
		r.status = ST_OK;
		inv = 0;
		n = regs.requested_intervals;
		if (regs.pulse_width == 0) begin
			r.status = ST_NO_PULSE;
			return r;
		end
		if (n <= 0 || n > MAX_INTERVALS) begin
			r.status = ST_BAD_COUNT;
			return r;
		end
		// lower the count until each interval is long enough
		while (longint'(regs.pulse_width) < longint'(MIN_INTERVAL_TICKS) * n) begin
			n -= 2;
			if (n <= 0) begin
				r.status = ST_BAD_COUNT;
				return r;
			end
		end
		un = n;
		r.intervals_used = un[9:0];
		if (idx >= un) begin
			r.status = ST_BEYOND;
			return r;
		end
		if (regs.peak_power > 40) begin
			span = 40;
			base = regs.peak_power - 40;
		end else begin
			span = regs.peak_power;
			base = 0;
		end
		p = 2 * idx + 1;
		if (regs.shape_mode == MODE_RISE || regs.shape_mode == MODE_FALL) begin
			q = 2 * un;
			if (regs.shape_mode == MODE_FALL)
				p = q - p;
			pwr = base + (2 * (p * (2 * q - p)) * span + q * q) / (2 * q * q);
			if ((regs.shape_mode == MODE_FALL && idx == 0) ||
			    (regs.shape_mode == MODE_RISE && idx == un - 1))
				pwr -= 6;
		end else if (regs.shape_mode == MODE_GAUSS) begin
			pwr = base + (2 * (p * (2 * un - p)) * span + un * un) / (2 * un * un);
		end else begin
			d = (p >= un) ? p - un : un - p;
			nn = un * un;
			au2 = (longint'(regs.herm_a) * d * d) / nn;
			bu2 = (longint'(regs.herm_b) * d * d) / nn;
			m = (au2 >= 65536) ? au2 - 65536 : 65536 - au2;
			lq = 0;
			if (m != 0) begin
				// log2 in Q16: leading one, then repeated squaring
				e = 0;
				while (e < 62 && (m >> (e + 1)) != 0)
					e++;
				x = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
				frac = 0;
				for (int k = 0; k < 16; k++) begin
					x = (x * x) >> 30;
					frac <<= 1;
					if (x >= (64'd1 << 31)) begin
						x >>= 1;
						frac |= 1;
					end
				end
				l2 = (longint'(e) - 16) * 65536 + longint'(frac);
				lq = (64'sd1 <<< 32) + l2 * 19728 - longint'(bu2) * 28462;
			end
			if (lq > 0) begin
				inv = au2 > 65536;
				pwr = base + ((longint'(unsigned'(lq)) * span + (64'd1 << 31)) >> 32);
			end else begin
				pwr = base;
			end
		end
		if (pwr > 63)
			pwr = 63;
		r.power_db = pwr[6:0];
		r.phase_inverted = inv;
		r.last_interval = (idx == un - 1);
		return r;
	endfunction

	// register copy, query prediction and result comparison
	always @(posedge clk or negedge arst_n) begin
		interval_result_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			regs <= '{shape_mode: MODE_GAUSS, requested_intervals: 10'd79, default: '0};
			errors <= 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHAPE_MODE: regs.shape_mode <= cfg_data[1:0];
					REG_REQ_INTV:   regs.requested_intervals <= cfg_data[9:0];
					REG_PULSE_W:    regs.pulse_width <= cfg_data[19:0];
					REG_PEAK_PWR:   regs.peak_power <= cfg_data[5:0];
					REG_HERM_A:     regs.herm_a <= cfg_data;
					REG_HERM_B:     regs.herm_b <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_results.push_back(interval_power(interval_index));
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no query outstanding");
					bad++;
				end else begin
					want = expected_results.pop_front();
					if (power_db !== want.power_db) begin
						$error("power_db: expected %0d, got %0d",
							$signed(want.power_db), $signed(power_db));
						bad++;
					end
					if (phase_inverted !== want.phase_inverted) begin
						$error("phase_inverted: expected %0d, got %0d",
							want.phase_inverted, phase_inverted);
						bad++;
					end
					if (intervals_used !== want.intervals_used) begin
						$error("intervals_used: expected %0d, got %0d",
							want.intervals_used, intervals_used);
						bad++;
					end
					if (last_interval !== want.last_interval) begin
						$error("last_interval: expected %0d, got %0d",
							want.last_interval, last_interval);
						bad++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

### dv/tb_shaped_pulse_power_table.sv
`timescale 1ns / 1ps
// testbench top for the shaped pulse power table: clock, reset, register
// writes and query stimulus; uses sppt_pkg, sppt_checker and the block
module tb_shaped_pulse_power_table;
	import sppt_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [9:0]  interval_index;
	logic        done;
	logic [6:0]  power_db;
	logic        phase_inverted;
	logic [9:0]  intervals_used;
	logic        last_interval;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          errors;
	int          pending;
	int          stall_cycles;
	bit          quiet;

	shaped_pulse_power_table u_dut (.*);

	sppt_checker u_checker (.*);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// stop when nothing has been transferred for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_shaped_pulse_power_table: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one query transfer, then an occasional gap
	task automatic query(logic [9:0] idx);
		start = 1'b1;
		interval_index = idx;
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// wait for the block to drain, then load every register
	task automatic load_regs(logic [1:0] mode, logic [9:0] req, logic [19:0] pw,
			logic [5:0] peak, logic [23:0] a, logic [23:0] b);
		start = 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		@(negedge clk);
		write_reg(REG_SHAPE_MODE, 24'(mode));
		write_reg(REG_REQ_INTV, 24'(req));
		write_reg(REG_PULSE_W, 24'(pw));
		write_reg(REG_PEAK_PWR, 24'(peak));
		write_reg(REG_HERM_A, a);
		write_reg(REG_HERM_B, b);
	endtask

	task automatic edge_queries(logic [9:0] req);
		query(10'd0);
		query(req - 10'd1);
		query(req);
		query(10'd1023);
	endtask

	initial begin
		logic [1:0]  mode;
		logic [9:0]  req;
		logic [19:0] pw;
		logic [23:0] a, b;
		start = 1'b0;
		interval_index = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: defaults (no pulse), bad counts, every shape at the edges
		query(10'd3);
		load_regs(MODE_GAUSS, 10'd0, 20'd1000, 6'd20, '0, '0);
		query(10'd0);
		load_regs(MODE_GAUSS, 10'd5, 20'd150, 6'd20, '0, '0);
		query(10'd0);
		load_regs(MODE_RISE, 10'd8, 20'd800, 6'd63, '0, '0);
		edge_queries(10'd8);
		load_regs(MODE_FALL, 10'd9, 20'd850, 6'd40, '0, '0);
		edge_queries(10'd7);
		load_regs(MODE_GAUSS, 10'd1023, 20'hFFFFF, 6'd63, '0, '0);
		edge_queries(10'd1023);
		load_regs(MODE_HERM, 10'd16, 20'd1600, 6'd63, 24'd262144, 24'd16384);
		edge_queries(10'd16);
		query(10'd4);
		load_regs(MODE_HERM, 10'd6, 20'd600, 6'd0, 24'hFFFFFF, 24'hFFFFFF);
		query(10'd0);
		query(10'd3);

		// random register settings, each followed by a run of queries
		for (int ph = 0; ph < 25; ph++) begin
			mode = $urandom_range(0, 3);
			req = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(1, 40))
				: 10'($urandom_range(0, 1023));
			pw = ($urandom_range(0, 9) < 8) ? 20'(req * 100 + $urandom_range(0, 300))
				: 20'($urandom_range(0, 20'hFFFFF));
			a = ($urandom_range(0, 2) == 0) ? 24'($urandom)
				: 24'($urandom_range(0, 24'h60000));
			b = ($urandom_range(0, 2) == 0) ? 24'($urandom)
				: 24'($urandom_range(0, 24'h18000));
			load_regs(mode, req, pw, 6'($urandom_range(0, 63)), a, b);
			quiet = (ph >= 22);
			for (int k = 0; k < 50; k++)
				query(($urandom_range(0, 9) < 9 && req != 0)
					? 10'($urandom_range(0, req - 1)) : 10'($urandom));
		end

		// drain and give the verdict
		start = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_shaped_pulse_power_table: PASS");
		else
			$display("tb_shaped_pulse_power_table: FAIL");
		$finish;
	end

endmodule

### shaped_pulse_power_table.f
rtl/core/sppt_pkg.sv
rtl/core/sppt_datapath.sv
rtl/core/sppt_ctrl.sv
rtl/core/shaped_pulse_power_table.sv
dv/sppt_checker.sv
dv/tb_shaped_pulse_power_table.sv
